### design/spq_pkg.sv
// spq_pkg: shared sizes, codes and types of the sorted priority queue
// used by spq_cell, sorted_priority_queue and spq_checker; depends on nothing
package spq_pkg;

	localparam int DEPTH       = 16;
	localparam int PRIO_W      = 16;
	localparam int VALUE_W     = 32;
	localparam int PORT_PRIO_W = 16;
	localparam int CNT_W       = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_INSERT  = 2'd0,
		CMD_EXTRACT = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_MODIFY  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_MISS  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INSERT,
		OP_MATCH,
		OP_REMOVE,
		OP_POP
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REMOVE,
		S_REINSERT
	} fsm_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [PRIO_W-1:0]  prio;
	} entry_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t op;
		entry_t   item;
	} cell_ctrl_t;

endpackage

### design/spq_cell.sv
// spq_cell: one slot of the sorted register row, holds one entry
// and trades it with its neighbours; depends on spq_pkg
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occupied,
	input  spq_pkg::entry_t    left_entry,
	input  logic               left_kept,
	input  spq_pkg::entry_t    right_entry,
	input  logic               after_in,
	output spq_pkg::entry_t    entry,
	output logic               kept,
	output logic               after_out,
	output logic               match,
	output logic               same
);
	import spq_pkg::*;

	entry_t entry_q;
	entry_t entry_d;
	logic   match_q;

	// entries of equal or higher priority stay ahead of a new one
	assign kept      = occupied && (entry_q.prio >= ctrl.item.prio);
	assign after_out = after_in | match_q;
	assign match     = match_q;
	// first match only, and its priority already equals the requested one
	assign same      = match_q && !after_in && (entry_q.prio == ctrl.item.prio);
	assign entry     = entry_q;

	always_comb begin
		entry_d = entry_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (!kept) begin
					entry_d = left_kept ? ctrl.item : left_entry;
				end
			end
			OP_REMOVE: begin
				if (after_out) begin
					entry_d = right_entry;
				end
			end
			OP_POP: begin
				entry_d = right_entry;
			end
			default: begin
				entry_d = entry_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.op == OP_MATCH) begin
			match_q <= occupied && (entry_q.value == ctrl.item.value);
		end
	end

endmodule

### design/sorted_priority_queue.sv
// sorted_priority_queue: top level, sequencer and row of spq_cell slots
// depends on spq_pkg and spq_cell
//
// Usage: one command item enters on the in channel (command, item_value,
// item_priority) and exactly one result item leaves on the out channel
// (out_value, out_priority, status, occupancy). Both channels move an item
// at a clock edge where valid is high and stall is low.
// The entries sit in a row of DEPTH cells sorted by descending priority,
// the front entry in cell 0. Every cell compares itself with the broadcast
// item in parallel and shifts towards its neighbour.
// Sequence: insert, extract and peek are carried out in the execute state
// and their result is registered in the output register. Modify matches,
// then checks, when the value is missing or its priority is unchanged, and
// otherwise matches, takes out and puts back in sorted place.
// The sequencer handles one item at a time; the next item is taken once
// the sequencer is idle and the output register is empty or being read.
// A stalled result stays in the output register unchanged.
// Reset empties the queue (count zero); no clearing pass is needed.
module sorted_priority_queue (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       command,
	input  logic signed [spq_pkg::VALUE_W-1:0] item_value,
	input  logic [15:0]                      item_priority,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [spq_pkg::VALUE_W-1:0] out_value,
	output logic [spq_pkg::PORT_PRIO_W-1:0]  out_priority,
	output logic [1:0]                       status,
	output logic [spq_pkg::CNT_W-1:0]        occupancy
);
	import spq_pkg::*;

	fsm_t            state_q;
	fsm_t            state_d;
	cmd_t            cmd_q;
	entry_t          item_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [PRIO_W-1:0]  out_prio_q;
	status_t            status_q;
	logic [CNT_W-1:0]   occ_q;

	logic               load_out;
	logic [VALUE_W-1:0] res_value;
	logic [PRIO_W-1:0]  res_prio;
	status_t            res_status;
	cell_ctrl_t         ctrl;
	cell_op_t           op;

	entry_t           cell_entry [DEPTH];
	logic [DEPTH-1:0] kept_v;
	logic [DEPTH-1:0] after_v;
	logic [DEPTH-1:0] match_v;
	logic [DEPTH-1:0] same_v;
	logic [DEPTH-1:0] occ_v;

	logic accept;
	logic full;
	logic empty;
	logic found;
	logic same_hit;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign found    = |match_v;
	assign same_hit = |same_v;

	assign ctrl.op   = op;
	assign ctrl.item = item_q;

	// row of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   left_k;
		logic   aft_in;

		assign occ_v[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_e = item_q;
			assign left_k = 1'b1;
			assign aft_in = 1'b0;
		end else begin : g_mid
			assign left_e = cell_entry[i-1];
			assign left_k = kept_v[i-1];
			assign aft_in = after_v[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = cell_entry[i];
		end else begin : g_inner
			assign right_e = cell_entry[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.occupied    (occ_v[i]),
			.left_entry  (left_e),
			.left_kept   (left_k),
			.right_entry (right_e),
			.after_in    (aft_in),
			.entry       (cell_entry[i]),
			.kept        (kept_v[i]),
			.after_out   (after_v[i]),
			.match       (match_v[i]),
			.same        (same_v[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = (cmd_q == CMD_MODIFY) ? S_REMOVE : S_IDLE;
			end
			S_REMOVE: begin
				state_d = (found && !same_hit) ? S_REINSERT : S_IDLE;
			end
			S_REINSERT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// cell commands, count update and result
	always_comb begin
		op         = OP_HOLD;
		count_d    = count_q;
		load_out   = 1'b0;
		res_value  = '0;
		res_prio   = '0;
		res_status = STAT_OK;
		case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_INSERT: begin
						load_out = 1'b1;
						if (full) begin
							res_status = STAT_FULL;
						end else begin
							op      = OP_INSERT;
							count_d = count_q + 1'b1;
						end
					end
					CMD_EXTRACT, CMD_PEEK: begin
						load_out = 1'b1;
						if (empty) begin
							res_status = STAT_EMPTY;
						end else begin
							res_value = cell_entry[0].value;
							res_prio  = cell_entry[0].prio;
							if (cmd_q == CMD_EXTRACT) begin
								op      = OP_POP;
								count_d = count_q - 1'b1;
							end
						end
					end
					CMD_MODIFY: begin
						op = OP_MATCH;
					end
					default: begin
						op = OP_HOLD;
					end
				endcase
			end
			S_REMOVE: begin
				if (!found || same_hit) begin
					load_out   = 1'b1;
					res_status = STAT_MISS;
				end else begin
					op      = OP_REMOVE;
					count_d = count_q - 1'b1;
				end
			end
			S_REINSERT: begin
				op       = OP_INSERT;
				count_d  = count_q + 1'b1;
				load_out = 1'b1;
			end
			default: begin
				op = OP_HOLD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= cmd_t'(command);
			item_q.value <= item_value;
			item_q.prio  <= PRIO_W'(item_priority);
		end
		if (load_out) begin
			out_value_q <= res_value;
			out_prio_q  <= res_prio;
			status_q    <= res_status;
			occ_q       <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_value    = out_value_q;
	assign out_priority = PORT_PRIO_W'(out_prio_q);
	assign status       = status_q;
	assign occupancy    = occ_q;

endmodule

### design/spq_checker.sv
// spq_port_checks: port-level assertions for sorted_priority_queue
// depends on spq_pkg; bound to the top level at the end of this file
module spq_port_checks (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic [1:0]                       command,
	input logic signed [spq_pkg::VALUE_W-1:0] item_value,
	input logic [15:0]                      item_priority,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [spq_pkg::VALUE_W-1:0] out_value,
	input logic [spq_pkg::PORT_PRIO_W-1:0]  out_priority,
	input logic [1:0]                       status,
	input logic [spq_pkg::CNT_W-1:0]        occupancy
);
	import spq_pkg::*;

	// count never goes past the number of cells
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occupancy <= CNT_W'(DEPTH)))
		else $error("occupancy beyond depth");

	// a refused insert only happens on a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_FULL) |-> (occupancy == CNT_W'(DEPTH)))
		else $error("full status with free cells");

	// empty status comes with zero count and zeroed entry fields
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_EMPTY) |->
			(occupancy == '0 && out_value == '0 && out_priority == '0))
		else $error("empty status with data");

	// one item at a time: the next cycle after acceptance stalls input
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item taken while busy");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(out_value) && $stable(status) && $stable(occupancy)))
		else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_port_checks u_spq_port_checks (.*);
